### hw/rtl/longest_increasing_run_length_macros.svh
// Assertion macros shared by the longest increasing run length RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LONGEST_INCREASING_RUN_LENGTH_MACROS_SVH
`define LONGEST_INCREASING_RUN_LENGTH_MACROS_SVH

// same-cycle implication, disabled during reset
`define LIRL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LIRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lirl_pkg.sv
// Shared types and constants for the longest increasing run length block.
// Depends on nothing; used by lirl_cell and the top level of the block.
package lirl_pkg;

   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned RUN_LENGTH_W = 11;

   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

### hw/rtl/lirl_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module lirl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### hw/rtl/lirl_cell.sv
// One search cell: holds the tails of one level of the implicit search tree
// and decides one bit of the insertion position. Depends on lirl_pkg, lirl_ram.
module lirl_cell #(
   parameter int unsigned MAX_LEN = 1024,
   parameter int unsigned LEVEL   = 0,
   localparam int unsigned POS_W  = $clog2(MAX_LEN + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                peek_valid,
   input  logic [POS_W-1:0]    peek_pos,
   input  logic                in_valid,
   input  lirl_pkg::value_type in_value,
   input  logic [POS_W-1:0]    in_count,
   input  logic [POS_W-1:0]    in_pos,
   output logic                out_valid,
   output lirl_pkg::value_type out_value,
   output logic [POS_W-1:0]    out_count,
   output logic [POS_W-1:0]    out_pos,
   input  logic                wr_en,
   input  logic [POS_W-1:0]    wr_pos,
   input  lirl_pkg::value_type wr_value
);

   localparam int unsigned DEPTH  = (MAX_LEN + 2**LEVEL) / (2**(LEVEL + 1));
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [POS_W-1:0] BIT     = POS_W'(2**LEVEL);
   localparam logic [POS_W-1:0] MASK    = POS_W'(2**(LEVEL + 1) - 1);
   localparam logic [POS_W-1:0] PATTERN = POS_W'(2**LEVEL - 1);

   logic [POS_W-1:0]            rd_base;
   logic [ADDR_W-1:0]           rd_addr_a;
   logic [ADDR_W-1:0]           rd_addr_b;
   logic [lirl_pkg::VALUE_W-1:0] rd_data_a;
   logic [lirl_pkg::VALUE_W-1:0] rd_data_b;
   logic [POS_W-1:0]            sel_vec;
   lirl_pkg::value_type         probe;
   logic [POS_W-1:0]            cand;
   logic                        take;
   logic [POS_W-1:0]            wr_base;
   logic                        wr_hit;

   logic                        out_valid_ff, out_valid_in;
   lirl_pkg::value_type         out_value_ff, out_value_in;
   logic [POS_W-1:0]            out_count_ff, out_count_in;
   logic [POS_W-1:0]            out_pos_ff, out_pos_in;

   // fetch both children while the upstream cell decides
   assign rd_base   = peek_pos >> (LEVEL + 1);
   assign rd_addr_a = rd_base[ADDR_W-1:0];
   assign rd_addr_b = rd_addr_a | ADDR_W'(1);

   assign sel_vec = in_pos >> (LEVEL + 1);
   assign probe   = sel_vec[0] ? rd_data_b : rd_data_a;
   assign cand    = in_pos | BIT;
   assign take    = (cand <= in_count) && (probe < in_value);

   assign wr_base = wr_pos >> (LEVEL + 1);
   assign wr_hit  = wr_en && ((wr_pos & MASK) == PATTERN);

   lirl_ram #(
      .WIDTH (lirl_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_hit),
      .wr_addr   (wr_base[ADDR_W-1:0]),
      .wr_data   (wr_value),
      .rd_en     (peek_valid),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      out_valid_in = in_valid;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      out_pos_in   = out_pos_ff;
      if (in_valid) begin
         out_value_in = in_value;
         out_count_in = in_count;
         out_pos_in   = take ? cand : in_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
      out_pos_ff   <= out_pos_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_count = out_count_ff;
   assign out_pos   = out_pos_ff;

endmodule

### hw/rtl/longest_increasing_run_length.sv
// Channel   | Direction | Handshake            | Payload
// req       | in        | req_valid/req_stall  | req_start_req, req_value
// rsp       | out       | rsp_valid/rsp_stall  | rsp_run_length, rsp_overflow
// One transaction at a time: a request passes the launch and stage registers,
// one search cell per position bit ($clog2(MAX_LEN+1) cells, 11 at 1024), the
// FINISH state and the write-back itself before its response is valid.
// The chain of search cells sets the latency: each decides one position bit.
// A stalled response holds the write-back until it drains; a new request is
// taken while a finished response still waits. Reset clears the stored length.
// Top level of the longest increasing run length block. Depends on lirl_pkg,
// lirl_cell and longest_increasing_run_length_macros.svh.
`include "longest_increasing_run_length_macros.svh"

module longest_increasing_run_length #(
   parameter int unsigned MAX_LEN = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_req,
   input  lirl_pkg::value_type                 req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lirl_pkg::RUN_LENGTH_W-1:0]   rsp_run_length,
   output logic                                rsp_overflow
);

   localparam int unsigned LVL   = $clog2(MAX_LEN + 1);
   localparam int unsigned POS_W = LVL;
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

   typedef enum logic [1:0] {IDLE, SEARCH, FINISH} state_type;

   // chain buses: cell b reads s[b+1], peeks s[b+2] and drives s[b]
   logic                s_valid [LVL+2];
   lirl_pkg::value_type s_value [LVL+2];
   logic [POS_W-1:0]    s_count [LVL+2];
   logic [POS_W-1:0]    s_pos   [LVL+2];

   state_type           state_ff, state_in;
   logic [POS_W-1:0]    used_len_ff, used_len_in;
   logic                launch_valid_ff, launch_valid_in;
   lirl_pkg::value_type launch_value_ff, launch_value_in;
   logic [POS_W-1:0]    launch_count_ff, launch_count_in;
   logic                stage_valid_ff, stage_valid_in;
   lirl_pkg::value_type stage_value_ff, stage_value_in;
   logic [POS_W-1:0]    stage_count_ff, stage_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [lirl_pkg::RUN_LENGTH_W-1:0] rsp_run_length_ff, rsp_run_length_in;
   logic                rsp_overflow_ff, rsp_overflow_in;

   logic                req_fire;
   logic                fin_fire;
   logic                fin_ovf;
   logic [POS_W:0]      fin_len;

   assign req_stall = (state_ff != IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign fin_fire  = (state_ff == FINISH) && !(rsp_valid_ff && rsp_stall);
   assign fin_ovf   = (s_pos[0] == MAX_POS);
   assign fin_len   = fin_ovf ? {1'b0, s_pos[0]} : ({1'b0, s_pos[0]} + (POS_W+1)'(1));

   assign s_valid[LVL+1] = launch_valid_ff;
   assign s_value[LVL+1] = launch_value_ff;
   assign s_count[LVL+1] = launch_count_ff;
   assign s_pos[LVL+1]   = '0;
   assign s_valid[LVL]   = stage_valid_ff;
   assign s_value[LVL]   = stage_value_ff;
   assign s_count[LVL]   = stage_count_ff;
   assign s_pos[LVL]     = '0;

   for (genvar g = 0; g < LVL; g++) begin : g_cell
      lirl_cell #(
         .MAX_LEN (MAX_LEN),
         .LEVEL   (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .peek_valid (s_valid[g+2]),
         .peek_pos   (s_pos[g+2]),
         .in_valid   (s_valid[g+1]),
         .in_value   (s_value[g+1]),
         .in_count   (s_count[g+1]),
         .in_pos     (s_pos[g+1]),
         .out_valid  (s_valid[g]),
         .out_value  (s_value[g]),
         .out_count  (s_count[g]),
         .out_pos    (s_pos[g]),
         .wr_en      (fin_fire && !fin_ovf),
         .wr_pos     (s_pos[0]),
         .wr_value   (s_value[0])
      );
   end

   always_comb begin
      state_in          = state_ff;
      used_len_in       = used_len_ff;
      launch_valid_in   = 1'b0;
      launch_value_in   = launch_value_ff;
      launch_count_in   = launch_count_ff;
      stage_valid_in    = launch_valid_ff;
      stage_value_in    = launch_value_ff;
      stage_count_in    = launch_count_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_run_length_in = rsp_run_length_ff;
      rsp_overflow_in   = rsp_overflow_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               launch_valid_in = 1'b1;
               launch_value_in = req_value;
               launch_count_in = req_start_req ? '0 : used_len_ff;
               state_in        = SEARCH;
            end
         end
         SEARCH: begin
            if (s_valid[0]) begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (fin_fire) begin
               used_len_in = ((s_pos[0] == s_count[0]) && !fin_ovf) ?
                             s_count[0] + POS_W'(1) : s_count[0];
               rsp_valid_in      = 1'b1;
               rsp_run_length_in = lirl_pkg::RUN_LENGTH_W'(fin_len);
               rsp_overflow_in   = fin_ovf;
               state_in          = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         used_len_ff     <= '0;
         launch_valid_ff <= 1'b0;
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         used_len_ff     <= used_len_in;
         launch_valid_ff <= launch_valid_in;
         stage_valid_ff  <= stage_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      launch_value_ff   <= launch_value_in;
      launch_count_ff   <= launch_count_in;
      stage_value_ff    <= stage_value_in;
      stage_count_ff    <= stage_count_in;
      rsp_run_length_ff <= rsp_run_length_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_length = rsp_run_length_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   `LIRL_ASSERT_NOW(a_used_len_range, clock, reset, 1'b1, used_len_ff <= MAX_POS, "stored length beyond table size")
   `LIRL_ASSERT_NOW(a_token_in_search, clock, reset, s_valid[0], state_ff == SEARCH, "search token outside search state")
   `LIRL_ASSERT_NOW(a_no_accept_in_flight, clock, reset, req_fire, !launch_valid_ff && !stage_valid_ff, "transaction accepted during search")
   `LIRL_ASSERT_NEXT(a_finish_loads_rsp, clock, reset, fin_fire, rsp_valid_ff && (state_ff == IDLE), "write-back without response")

endmodule
